// ===== rtl/ptq_pkg.sv =====
// shared types and constants for the priority task queue
`default_nettype none
package ptq_pkg;
  localparam int QueueDepth   = 16;
  localparam int HistDepth    = 16;
  localparam int QIdxW        = $clog2(QueueDepth);
  localparam int HIdxW        = $clog2(HistDepth);
  localparam int HCntW        = $clog2(HistDepth + 1);

  // entry as carried in history
  typedef struct packed {
    logic [15:0]        id;
    logic [1:0]         kind;
    logic signed [15:0] number;
    logic signed [7:0]  prio;
  } entry_t;

  // queue slot content: entry plus arrival stamp
  typedef struct packed {
    entry_t      ent;
    logic [15:0] stamp;
  } qslot_t;

  localparam int EntryW = $bits(entry_t);
  localparam int QSlotW = $bits(qslot_t);

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_PROCESS = 2'd1,
    OP_UNDO    = 2'd2,
    OP_REDO    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_NO_UNDO = 3'd2,
    ST_NO_REDO = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_HREAD,
    S_SHIFT,
    S_DONE
  } state_e;

  // circular history stack pointers
  typedef struct packed {
    logic [HIdxW-1:0] base;
    logic [HCntW-1:0] cnt;
  } hptr_t;
endpackage
`default_nettype wire

// ===== rtl/ptq_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none
module ptq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/priority_task_queue_undo_redo.sv =====
// priority task queue with undo and redo history stacks
// add and refused commands go straight to S_DONE; undo/redo pass S_HREAD and
// S_SHIFT; process passes S_SCAN and, if a task was found, S_HREAD and S_SHIFT
// the process scan reads one queue slot per cycle from the queue ram
// one command at a time; in_stall_o is high until the result beat is taken
// reset clears valid bits, stack counts and counters; rams are not cleared
`default_nettype none
module priority_task_queue_undo_redo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          op_i,
  input  wire logic [1:0]          kind_i,
  input  wire logic signed [15:0]  number_i,
  input  wire logic signed [7:0]   priority_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [2:0]               status_o,
  output logic                     moved_o,
  output logic [15:0]              task_id_o,
  output logic [1:0]               task_kind_o,
  output logic signed [15:0]       task_number_o,
  output logic signed [7:0]        task_priority_o
);
  import ptq_pkg::*;

  state_e state_q, state_d;
  logic [QueueDepth-1:0] qvalid_q;
  hptr_t undo_q, redo_q;
  logic [15:0] id_q, arr_q;
  op_e op_q;
  entry_t in_ent_q;
  logic [QIdxW:0] scan_q;
  logic found_q;
  logic [QIdxW-1:0] best_q;
  logic signed [7:0] best_pri_q;
  logic [15:0] best_age_q;
  logic [QIdxW-1:0] free_idx;
  logic have_free;

  // ram ports
  logic q_we, u_we, r_we;
  logic [QIdxW-1:0] q_waddr, q_raddr;
  qslot_t q_wdata, q_rdata;
  logic [HIdxW-1:0] u_waddr, u_raddr, r_waddr, r_raddr;
  entry_t u_wdata, u_rdata, r_wdata, r_rdata;

  ptq_ram #(.Width(QSlotW), .Depth(QueueDepth)) u_qram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata));
  ptq_ram #(.Width(EntryW), .Depth(HistDepth)) u_uram (
    .clk_i, .we_i(u_we), .waddr_i(u_waddr), .wdata_i(u_wdata),
    .raddr_i(u_raddr), .rdata_o(u_rdata));
  ptq_ram #(.Width(EntryW), .Depth(HistDepth)) u_rram (
    .clk_i, .we_i(r_we), .waddr_i(r_waddr), .wdata_i(r_wdata),
    .raddr_i(r_raddr), .rdata_o(r_rdata));

  // lowest free queue slot
  always_comb begin
    free_idx  = '0;
    have_free = 1'b0;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (!qvalid_q[i]) begin
        free_idx  = QIdxW'(i);
        have_free = 1'b1;
      end
    end
  end

  logic accept_in;
  assign accept_in = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // scan compare on the slot read last cycle
  logic [QIdxW-1:0] scan_slot;
  logic [15:0] cand_age;
  logic cand_wins;
  assign scan_slot = scan_q[QIdxW-1:0] - QIdxW'(1);
  assign cand_age = arr_q - q_rdata.stamp;
  assign cand_wins = qvalid_q[scan_slot] && (!found_q ||
      q_rdata.ent.prio > best_pri_q ||
      (q_rdata.ent.prio == best_pri_q && cand_age > best_age_q));

  // top-of-stack addresses
  logic [HIdxW-1:0] u_top, r_top;
  assign u_top = undo_q.base + HIdxW'(undo_q.cnt - HCntW'(1));
  assign r_top = redo_q.base + HIdxW'(redo_q.cnt - HCntW'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept_in) begin
        case (op_e'(op_i))
          OP_ADD:     state_d = S_DONE;
          OP_PROCESS: state_d = S_SCAN;
          OP_UNDO:    state_d = (undo_q.cnt == '0) ? S_DONE : S_HREAD;
          OP_REDO:    state_d = (redo_q.cnt == '0 || !have_free) ? S_DONE : S_HREAD;
          default:    state_d = S_DONE;
        endcase
      end
      S_SCAN:  if (scan_q == (QIdxW+1)'(QueueDepth)) state_d = found_q || cand_wins
                                                           ? S_HREAD : S_DONE;
      S_HREAD: state_d = S_SHIFT;
      S_SHIFT: state_d = S_DONE;
      S_DONE:  if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ram addressing
  always_comb begin
    q_raddr = (state_q == S_SCAN && scan_q != (QIdxW+1)'(QueueDepth)) ?
              scan_q[QIdxW-1:0] : best_q;
    if (state_q == S_IDLE) q_raddr = '0;
    u_raddr = u_top;
    r_raddr = r_top;
    q_we = 1'b0; q_waddr = free_idx; q_wdata = '0;
    u_we = 1'b0; u_waddr = '0; u_wdata = r_rdata;
    r_we = 1'b0; r_waddr = '0; r_wdata = u_rdata;
    if (state_q == S_IDLE && accept_in && op_e'(op_i) == OP_ADD && have_free) begin
      q_we = 1'b1;
      q_wdata.ent.id = id_q + 16'd1;
      q_wdata.ent.kind = kind_i;
      q_wdata.ent.number = number_i;
      q_wdata.ent.prio = priority_req_i;
      q_wdata.stamp = arr_q;
    end
    if (state_q == S_SHIFT) begin
      case (op_q)
        OP_PROCESS: begin
          u_we = 1'b1;
          u_wdata = q_rdata.ent;
          u_waddr = undo_q.base + HIdxW'(undo_q.cnt);
        end
        OP_UNDO: begin
          r_we = 1'b1;
          r_waddr = redo_q.base + HIdxW'(redo_q.cnt);
        end
        OP_REDO: begin
          u_we = 1'b1;
          u_waddr = undo_q.base + HIdxW'(undo_q.cnt);
          q_we = 1'b1;
          q_wdata.ent = r_rdata;
          q_wdata.stamp = arr_q;
        end
        default: ;
      endcase
    end
  end

  // push helper: full stack drops oldest by moving base
  function automatic hptr_t push_ptr(hptr_t p);
    hptr_t r;
    r = p;
    if (p.cnt == HCntW'(HistDepth)) r.base = p.base + HIdxW'(1);
    else r.cnt = p.cnt + HCntW'(1);
    return r;
  endfunction

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      qvalid_q <= '0;
      undo_q <= '0;
      redo_q <= '0;
      id_q <= '0;
      arr_q <= '0;
      scan_q <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && accept_in) begin
        scan_q <= '0;
        found_q <= 1'b0;
        if (op_e'(op_i) == OP_ADD && have_free) begin
          qvalid_q[free_idx] <= 1'b1;
          id_q <= id_q + 16'd1;
          arr_q <= arr_q + 16'd1;
        end
      end
      if (state_q == S_SCAN) begin
        scan_q <= scan_q + 1'b1;
        if (scan_q != '0 && cand_wins) found_q <= 1'b1;
      end
      if (state_q == S_HREAD) begin
        case (op_q)
          OP_PROCESS: qvalid_q[best_q] <= 1'b0;
          OP_UNDO: undo_q.cnt <= undo_q.cnt - HCntW'(1);
          OP_REDO: redo_q.cnt <= redo_q.cnt - HCntW'(1);
          default: ;
        endcase
      end
      if (state_q == S_SHIFT) begin
        case (op_q)
          OP_PROCESS: undo_q <= push_ptr(undo_q);
          OP_UNDO:    redo_q <= push_ptr(redo_q);
          OP_REDO: begin
            undo_q <= push_ptr(undo_q);
            qvalid_q[free_idx] <= 1'b1;
            arr_q <= arr_q + 16'd1;
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  entry_t res_q;
  status_e stat_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept_in) begin
      op_q <= op_e'(op_i);
      in_ent_q.id <= id_q + 16'd1;
      in_ent_q.kind <= kind_i;
      in_ent_q.number <= number_i;
      in_ent_q.prio <= priority_req_i;
      res_q <= '0;
      case (op_e'(op_i))
        OP_ADD: begin
          stat_q <= have_free ? ST_OK : ST_FULL;
          if (have_free) begin
            res_q.id <= id_q + 16'd1;
            res_q.kind <= kind_i;
            res_q.number <= number_i;
            res_q.prio <= priority_req_i;
          end
        end
        OP_PROCESS: stat_q <= ST_EMPTY;
        OP_UNDO:    stat_q <= (undo_q.cnt == '0) ? ST_NO_UNDO : ST_OK;
        OP_REDO:    stat_q <= (redo_q.cnt == '0) ? ST_NO_REDO :
                              (!have_free ? ST_FULL : ST_OK);
        default:    stat_q <= ST_OK;
      endcase
    end
    if (state_q == S_SCAN && scan_q != '0 && cand_wins) begin
      best_q <= scan_slot;
      best_pri_q <= q_rdata.ent.prio;
      best_age_q <= cand_age;
    end
    if (state_q == S_SHIFT) begin
      stat_q <= ST_OK;
      case (op_q)
        OP_PROCESS: res_q <= q_rdata.ent;
        OP_UNDO:    res_q <= u_rdata;
        OP_REDO:    res_q <= r_rdata;
        default:    res_q <= in_ent_q;
      endcase
    end
  end

  // result beat
  assign out_valid_o = (state_q == S_DONE);
  assign status_o = stat_q;
  assign moved_o = (stat_q == ST_OK);
  assign task_id_o = res_q.id;
  assign task_kind_o = res_q.kind;
  assign task_number_o = res_q.number;
  assign task_priority_o = res_q.prio;

  // history counts stay in range
  a_undo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    undo_q.cnt <= HCntW'(HistDepth)) else $error("undo count overflow");
  a_redo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    redo_q.cnt <= HCntW'(HistDepth)) else $error("redo count overflow");
  // a successful add sets one valid bit more
  a_add_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && accept_in && op_i == OP_ADD && have_free) |=>
    $countones(qvalid_q) == $countones($past(qvalid_q)) + 1)
    else $error("add did not fill a slot");
endmodule
`default_nettype wire
